>>> rtl/ppa_pkg.sv
package ppa_pkg;

  // request codes carried in the low bits of the input tuser
  localparam logic [2:0] REQ_ROT_WORLD   = 3'd0;
  localparam logic [2:0] REQ_ROT_LOCAL   = 3'd1;
  localparam logic [2:0] REQ_SHIFT_WORLD = 3'd2;
  localparam logic [2:0] REQ_SHIFT_LOCAL = 3'd3;
  localparam logic [2:0] REQ_COMPUTE     = 3'd4;

  // shape codes
  localparam logic [2:0] SHAPE_BOX      = 3'd0;
  localparam logic [2:0] SHAPE_SPHERE   = 3'd1;
  localparam logic [2:0] SHAPE_CAPSULE  = 3'd2;
  localparam logic [2:0] SHAPE_CONE     = 3'd3;
  localparam logic [2:0] SHAPE_CYLINDER = 3'd4;

  localparam logic [1:0] ROW_LAST = 2'd2;

  localparam logic signed [31:0] SAT_POS = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

  // which sum the shared multiplier is working on
  typedef enum logic [1:0] {
    PH_ROT,
    PH_SHIFT,
    PH_EXT
  } phase_e;

  // control that travels with each product through the mac
  typedef struct packed {
    phase_e     phase;
    logic [1:0] i;
    logic [1:0] m;
    logic       first;
    logic       last;
    logic       abs_mode;
    logic       keep;
    logic       halve_term;
    logic       halve_sum;
  } mac_ctl_t;

endpackage

>>> rtl/ppa_mac.sv
module ppa_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         issue_i,
  input  logic signed [31:0]           op_a_i,
  input  logic signed [31:0]           op_b_i,
  input  ppa_pkg::mac_ctl_t            ctl_i,
  input  logic signed [65-FRAC_BITS:0] init_i,
  output logic                         wb_valid_o,
  output ppa_pkg::mac_ctl_t            wb_ctl_o,
  output logic signed [65-FRAC_BITS:0] wb_value_o
);

  localparam int ACC_W = 66 - FRAC_BITS;

  logic                     valid_q;
  logic signed [63:0]       prod_d;
  logic signed [63:0]       prod_q;
  ppa_pkg::mac_ctl_t        ctl_q;
  logic signed [ACC_W-1:0]  init_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [63:0]              mag;
  logic [63:0]              shifted;
  logic signed [ACC_W-1:0]  term_mag;
  logic signed [ACC_W-1:0]  term_s;
  logic signed [ACC_W-1:0]  term_h;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  sum;

  // signed 32x32 product, registered before any further use
  assign prod_d = op_a_i * op_b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= prod_d;
      ctl_q  <= ctl_i;
      init_q <= init_i;
    end
    if (valid_q) begin
      acc_q <= sum;
    end
  end

  // truncate the magnitude towards zero, then restore the sign if wanted
  always_comb begin
    mag      = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    shifted  = mag >> FRAC_BITS;
    term_mag = ACC_W'(shifted);
    term_s   = (ctl_q.abs_mode || !prod_q[63]) ? term_mag : -term_mag;
    term_h   = ctl_q.halve_term ? (term_s >>> 1) : term_s;
    term     = ctl_q.keep ? term_h : '0;
    base     = ctl_q.first ? init_q : acc_q;
    sum      = base + term;
  end

  assign wb_valid_o = valid_q && ctl_q.last;
  assign wb_ctl_o   = ctl_q;
  assign wb_value_o = ctl_q.halve_sum ? (sum >>> 1) : sum;

endmodule

>>> rtl/posed_primitive_aabb.sv
// Axis-aligned bounding box of a posed primitive, Q(32-FRAC_BITS).FRAC_BITS fixed point.
// Load transactions (world or local rotation row, world or local shift) are taken while
// idle and give no result. A compute transaction composes R = Rw*Rl and
// T = Rw*tl + tw, builds the half extent of a box, sphere, capsule, cone or cylinder
// from |R| and the shape dimensions, and returns the corners T - h and T + h,
// saturated to 32 bits, with tuser set when any element of R or T or any corner
// saturated. All 45 products of a compute go through one 32x32 multiplier, one per
// cycle, with a registered accumulate stage behind it; the extent pass always runs
// nine slots whatever the shape. A compute then passes through a drain state and six
// corner steps with one shared adder and saturator before its result is shown, and
// the next transaction is taken no earlier than the cycle after the result
// transaction completes. Unknown request codes, a rotation row index of three
// and unknown shape codes are swallowed without a result.
module posed_primitive_aabb #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // value_a, value_b, value_c
  input  logic [7:0]   s_axis_tuser,  // req_type[2:0], row_index[4:3], shape_kind[7:5]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,  // min_x, min_y, min_z, max_x, max_y, max_z
  output logic [0:0]   m_axis_tuser   // overflow
);

  localparam int ACC_W = 66 - FRAC_BITS;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_CORNER,
    ST_OUT
  } state_e;

  state_e                  state_q;
  ppa_pkg::phase_e         phase_q;
  logic [1:0]              i_q;
  logic [1:0]              m_q;
  logic [1:0]              n_q;
  logic                    ovf_q;

  // unpacked input transaction
  logic [2:0]              req_type;
  logic [1:0]              row_index;
  logic [2:0]              shape_kind;
  logic signed [31:0]      value_a;
  logic signed [31:0]      value_b;
  logic signed [31:0]      value_c;
  logic                    in_acc;

  // pose and shape state
  logic signed [31:0]      rw_q [9];
  logic signed [31:0]      rl_q [9];
  logic signed [31:0]      tw_q [3];
  logic signed [31:0]      tl_q [3];
  logic [2:0]              kind_q;
  logic signed [31:0]      dim_a_q;
  logic signed [31:0]      dim_b_q;
  logic signed [31:0]      dim_c_q;

  // composed pose, extents and corners
  logic signed [31:0]      r_q  [9];
  logic signed [31:0]      t_q  [3];
  logic signed [ACC_W-1:0] h_q  [3];
  logic signed [31:0]      lo_q [3];
  logic signed [31:0]      hi_q [3];

  // multiplier issue side
  logic [3:0]              idx_a;
  logic [3:0]              idx_b;
  logic signed [31:0]      op_a;
  logic signed [31:0]      op_b;
  logic signed [31:0]      dim_sel;
  logic signed [ACC_W-1:0] init_val;
  ppa_pkg::mac_ctl_t       ctl;
  logic                    issue;

  // writeback side
  logic                    wb_valid;
  ppa_pkg::mac_ctl_t       wb_ctl;
  logic signed [ACC_W-1:0] wb_value;
  logic                    wb_fits;
  logic signed [31:0]      wb_sat;
  logic [3:0]              wb_idx;

  // corner side
  logic signed [ACC_W-1:0] t_ext;
  logic signed [ACC_W-1:0] corner_sum;
  logic                    corner_fits;
  logic signed [31:0]      corner_sat;

  assign req_type   = s_axis_tuser[2:0];
  assign row_index  = s_axis_tuser[4:3];
  assign shape_kind = s_axis_tuser[7:5];
  assign value_a    = s_axis_tdata[31:0];
  assign value_b    = s_axis_tdata[63:32];
  assign value_c    = s_axis_tdata[95:64];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // operand selection: rotation pass uses Rw row i and Rl column m, shift pass
  // Rw row i and tl, extent pass row i of the composed R and a shape dimension
  always_comb begin
    idx_a = 4'(i_q) * 4'd3 + 4'(n_q);
    idx_b = 4'(n_q) * 4'd3 + 4'(m_q);

    priority if (kind_q == ppa_pkg::SHAPE_BOX) begin
      dim_sel = (n_q == 2'd0) ? dim_a_q : ((n_q == 2'd1) ? dim_b_q : dim_c_q);
    end else if (kind_q == ppa_pkg::SHAPE_CAPSULE) begin
      dim_sel = dim_b_q;
    end else if (kind_q == ppa_pkg::SHAPE_SPHERE) begin
      dim_sel = dim_a_q;
    end else begin
      dim_sel = (n_q == ppa_pkg::ROW_LAST) ? dim_b_q : dim_a_q;
    end

    op_a     = rw_q[idx_a];
    op_b     = rl_q[idx_b];
    init_val = '0;
    ctl      = '0;
    ctl.phase = phase_q;
    ctl.i     = i_q;
    ctl.m     = m_q;
    ctl.first = (n_q == 2'd0);
    ctl.last  = (n_q == ppa_pkg::ROW_LAST);
    ctl.keep  = 1'b1;

    unique case (phase_q)
      ppa_pkg::PH_ROT: begin
        op_b = rl_q[idx_b];
      end
      ppa_pkg::PH_SHIFT: begin
        op_b     = tl_q[n_q];
        init_val = {{(ACC_W-32){tw_q[i_q][31]}}, tw_q[i_q]};
      end
      ppa_pkg::PH_EXT: begin
        op_a         = r_q[idx_a];
        op_b         = dim_sel;
        ctl.abs_mode = 1'b1;
        if (kind_q == ppa_pkg::SHAPE_SPHERE) begin
          ctl.keep = 1'b0;
          init_val = {{(ACC_W-32){dim_a_q[31]}}, dim_a_q};
        end else if (kind_q == ppa_pkg::SHAPE_CAPSULE) begin
          // only the axial term counts, halved, on top of the radius
          ctl.keep       = (n_q == ppa_pkg::ROW_LAST);
          ctl.halve_term = 1'b1;
          init_val       = {{(ACC_W-32){dim_a_q[31]}}, dim_a_q};
        end else if (kind_q == ppa_pkg::SHAPE_BOX) begin
          ctl.halve_sum = (n_q == ppa_pkg::ROW_LAST);
        end else begin
          // cone and cylinder: half the axial length
          ctl.halve_term = (n_q == ppa_pkg::ROW_LAST);
        end
      end
      default: begin
        op_b = rl_q[idx_b];
      end
    endcase
  end

  assign issue = (state_q == ST_RUN);

  ppa_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .op_a_i     (op_a),
    .op_b_i     (op_b),
    .ctl_i      (ctl),
    .init_i     (init_val),
    .wb_valid_o (wb_valid),
    .wb_ctl_o   (wb_ctl),
    .wb_value_o (wb_value)
  );

  // saturation of a finished sum of the rotation or shift pass
  always_comb begin
    wb_fits = (&wb_value[ACC_W-1:31]) || !(|wb_value[ACC_W-1:31]);
    wb_sat  = wb_fits ? wb_value[31:0]
                      : (wb_value[ACC_W-1] ? ppa_pkg::SAT_NEG : ppa_pkg::SAT_POS);
    wb_idx  = 4'(wb_ctl.i) * 4'd3 + 4'(wb_ctl.m);
  end

  // one shared adder for the six corners: axis n, lower side when m is zero
  always_comb begin
    t_ext       = {{(ACC_W-32){t_q[n_q][31]}}, t_q[n_q]};
    corner_sum  = m_q[0] ? (t_ext + h_q[n_q]) : (t_ext - h_q[n_q]);
    corner_fits = (&corner_sum[ACC_W-1:31]) || !(|corner_sum[ACC_W-1:31]);
    corner_sat  = corner_fits ? corner_sum[31:0]
                              : (corner_sum[ACC_W-1] ? ppa_pkg::SAT_NEG : ppa_pkg::SAT_POS);
  end

  // sequencer, pose registers and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= ppa_pkg::PH_ROT;
      i_q     <= '0;
      m_q     <= '0;
      n_q     <= '0;
      ovf_q   <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        rw_q[k] <= (k % 4 == 0) ? ONE_FX : '0;
        rl_q[k] <= (k % 4 == 0) ? ONE_FX : '0;
      end
      for (int k = 0; k < 3; k++) begin
        tw_q[k] <= '0;
        tl_q[k] <= '0;
      end
    end else begin
      // saturation in R or T sticks for the rest of this compute
      if (wb_valid && (wb_ctl.phase != ppa_pkg::PH_EXT) && !wb_fits) begin
        ovf_q <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (req_type)
              ppa_pkg::REQ_ROT_WORLD: begin
                for (int r = 0; r < 3; r++) begin
                  if (row_index == 2'(r)) begin
                    rw_q[3*r]   <= value_a;
                    rw_q[3*r+1] <= value_b;
                    rw_q[3*r+2] <= value_c;
                  end
                end
              end
              ppa_pkg::REQ_ROT_LOCAL: begin
                for (int r = 0; r < 3; r++) begin
                  if (row_index == 2'(r)) begin
                    rl_q[3*r]   <= value_a;
                    rl_q[3*r+1] <= value_b;
                    rl_q[3*r+2] <= value_c;
                  end
                end
              end
              ppa_pkg::REQ_SHIFT_WORLD: begin
                tw_q[0] <= value_a;
                tw_q[1] <= value_b;
                tw_q[2] <= value_c;
              end
              ppa_pkg::REQ_SHIFT_LOCAL: begin
                tl_q[0] <= value_a;
                tl_q[1] <= value_b;
                tl_q[2] <= value_c;
              end
              ppa_pkg::REQ_COMPUTE: begin
                if (shape_kind <= ppa_pkg::SHAPE_CYLINDER) begin
                  state_q <= ST_RUN;
                  phase_q <= ppa_pkg::PH_ROT;
                  i_q     <= '0;
                  m_q     <= '0;
                  n_q     <= '0;
                  ovf_q   <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_RUN: begin
          // n steps the terms of a sum, m the rotation column, i the row
          if (n_q != ppa_pkg::ROW_LAST) begin
            n_q <= n_q + 2'd1;
          end else begin
            n_q <= '0;
            unique case (phase_q)
              ppa_pkg::PH_ROT: begin
                if (m_q != ppa_pkg::ROW_LAST) begin
                  m_q <= m_q + 2'd1;
                end else begin
                  m_q <= '0;
                  if (i_q != ppa_pkg::ROW_LAST) begin
                    i_q <= i_q + 2'd1;
                  end else begin
                    i_q     <= '0;
                    phase_q <= ppa_pkg::PH_SHIFT;
                  end
                end
              end
              ppa_pkg::PH_SHIFT: begin
                if (i_q != ppa_pkg::ROW_LAST) begin
                  i_q <= i_q + 2'd1;
                end else begin
                  i_q     <= '0;
                  phase_q <= ppa_pkg::PH_EXT;
                end
              end
              ppa_pkg::PH_EXT: begin
                if (i_q != ppa_pkg::ROW_LAST) begin
                  i_q <= i_q + 2'd1;
                end else begin
                  i_q     <= '0;
                  state_q <= ST_DRAIN;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end

        ST_DRAIN: begin
          // last extent leaves the accumulate stage this cycle
          state_q <= ST_CORNER;
          n_q     <= '0;
          m_q     <= '0;
        end

        ST_CORNER: begin
          if (!corner_fits) begin
            ovf_q <= 1'b1;
          end
          if (n_q != ppa_pkg::ROW_LAST) begin
            n_q <= n_q + 2'd1;
          end else begin
            n_q <= '0;
            if (m_q == 2'd0) begin
              m_q <= 2'd1;
            end else begin
              m_q     <= '0;
              state_q <= ST_OUT;
            end
          end
        end

        ST_OUT: begin
          if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (in_acc && (req_type == ppa_pkg::REQ_COMPUTE)) begin
      kind_q  <= shape_kind;
      dim_a_q <= value_a;
      dim_b_q <= value_b;
      dim_c_q <= value_c;
    end

    if (wb_valid) begin
      unique case (wb_ctl.phase)
        ppa_pkg::PH_ROT:   r_q[wb_idx]   <= wb_sat;
        ppa_pkg::PH_SHIFT: t_q[wb_ctl.i] <= wb_sat;
        ppa_pkg::PH_EXT:   h_q[wb_ctl.i] <= wb_value;
        default: begin
        end
      endcase
    end

    if (state_q == ST_CORNER) begin
      if (m_q[0]) begin
        hi_q[n_q] <= corner_sat;
      end else begin
        lo_q[n_q] <= corner_sat;
      end
    end
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {hi_q[2], hi_q[1], hi_q[0], lo_q[2], lo_q[1], lo_q[0]};
  assign m_axis_tuser  = ovf_q;

endmodule
